[hdl/iac_pkg.sv]
// package with types, constants and helpers for the ignition advance calculator
package iac_pkg;

  localparam int unsigned CurvePointsDefault = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 49;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START    = 3'd0,
    REG_IDLE     = 3'd1,
    REG_TSS      = 3'd2,
    REG_RUMBLE   = 3'd3,
    REG_BACKFIRE = 3'd4,
    REG_BF_TIMES = 3'd5,
    REG_LIMIT    = 3'd6
  } reg_idx_e;

  typedef enum logic [0:0] {
    OP_LOAD    = 1'b0,
    OP_COMPUTE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    TSS_AUTO = 2'd0,
    TSS_ON   = 2'd1,
    TSS_OFF  = 2'd2,
    TSS_RSVD = 2'd3
  } tss_mode_e;

  typedef enum logic [1:0] {
    LIM_NORMAL = 2'd0,
    LIM_SOFT   = 2'd1,
    LIM_HARD   = 2'd2
  } lim_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_MOD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic        opcode;
    logic [3:0]  point_index;
    logic [15:0] point_rpm;
    logic signed [15:0] point_timing;
    logic [15:0] rpm;
    logic [31:0] now_ms;
    logic        tss_pin;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] final_timing;
    logic signed [15:0] base_timing;
    logic        starting;
    logic        idle_active;
    logic        tss_active;
    logic        rumble_active;
    logic        backfire_active;
    logic [1:0]  limiter_state;
  } out_item_t;

  typedef struct packed {
    logic [31:0] start_cfg;
    logic [48:0] idle_cfg;
    logic [17:0] tss_cfg;
    logic [48:0] rumble_cfg;
    logic [48:0] backfire_cfg;
    logic [31:0] backfire_times;
    logic [31:0] limit_cfg;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic write_pt;
    logic scan_start;
    logic scan_step;
    logic div_start;
    logic div_step;
    logic modify;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_compute;
    logic scan_done;
    logic need_div;
    logic div_done;
  } dp_sts_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) return 16'sh7fff;
    if (v < -18'sd32768) return -16'sh8000;
    return v[15:0];
  endfunction

endpackage

[hdl/iac_if.sv]
// valid ready channel carrying one payload item
interface iac_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/iac_cfg_if.sv]
// configuration write channel
interface iac_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [iac_pkg::CfgIdxW-1:0]  index;
  logic [iac_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/ignition_advance_calculator.sv]
// top level of the ignition advance calculator
// sequencing: a load item is captured, then written in the read state; a compute item
// scans the curve, runs the 33 step serial divider to interpolate, then the modifiers
// throughput: one item at a time, set by the curve scan over the single read port
// and the bit serial divider; a result is held until the output is ready
// reset: asynchronous active low; config registers take reset values, backfire state
// clears, curve points are undefined until loaded
module ignition_advance_calculator #(
  parameter int unsigned CURVE_POINTS = iac_pkg::CurvePointsDefault
) (
  input logic clk_i,
  input logic rst_ni,
  iac_if.sink     in_if,
  iac_if.source   out_if,
  iac_cfg_if.sink cfg_if
);
  iac_pkg::cfg_t    cfg_q;
  iac_pkg::dp_cmd_t cmd;
  iac_pkg::dp_sts_t sts;
  iac_pkg::out_item_t res;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_cfg <= '0;
      cfg_q.idle_cfg <= '0;
      cfg_q.tss_cfg <= 18'd2;
      cfg_q.rumble_cfg <= '0;
      cfg_q.backfire_cfg <= '0;
      cfg_q.backfire_times <= '0;
      cfg_q.limit_cfg <= '1;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        iac_pkg::REG_START:    cfg_q.start_cfg <= cfg_if.data[31:0];
        iac_pkg::REG_IDLE:     cfg_q.idle_cfg <= cfg_if.data;
        iac_pkg::REG_TSS:      cfg_q.tss_cfg <= cfg_if.data[17:0];
        iac_pkg::REG_RUMBLE:   cfg_q.rumble_cfg <= cfg_if.data;
        iac_pkg::REG_BACKFIRE: cfg_q.backfire_cfg <= cfg_if.data;
        iac_pkg::REG_BF_TIMES: cfg_q.backfire_times <= cfg_if.data[31:0];
        iac_pkg::REG_LIMIT:    cfg_q.limit_cfg <= cfg_if.data[31:0];
        default: ;
      endcase
    end
  end

  iac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  iac_dp #(.CurvePoints(CURVE_POINTS)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (in_if.data),
    .cfg_i  (cfg_q),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (res)
  );

  assign out_if.data = res;
endmodule

[hdl/iac_ram.sv]
// generic ram with one write port and one registered read port
module iac_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

[hdl/iac_ctrl.sv]
// controller state machine sequencing load and compute items
module iac_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  iac_pkg::dp_sts_t  sts_i,
  output iac_pkg::dp_cmd_t  cmd_o
);
  iac_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iac_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      iac_pkg::ST_IDLE: if (in_valid_i) state_d = iac_pkg::ST_READ;
      iac_pkg::ST_READ: begin
        if (sts_i.is_compute) state_d = iac_pkg::ST_SCAN;
        else state_d = iac_pkg::ST_IDLE;
      end
      iac_pkg::ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = sts_i.need_div ? iac_pkg::ST_MUL : iac_pkg::ST_MOD;
        end
      end
      iac_pkg::ST_MUL: state_d = iac_pkg::ST_DIV;
      iac_pkg::ST_DIV: if (sts_i.div_done) state_d = iac_pkg::ST_MOD;
      iac_pkg::ST_MOD: state_d = iac_pkg::ST_OUT;
      iac_pkg::ST_OUT: if (out_ready_i) state_d = iac_pkg::ST_IDLE;
      default: state_d = iac_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      iac_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      iac_pkg::ST_READ: begin
        cmd_o.write_pt   = !sts_i.is_compute;
        cmd_o.scan_start = sts_i.is_compute;
      end
      iac_pkg::ST_SCAN: cmd_o.scan_step = 1'b1;
      iac_pkg::ST_MUL:  cmd_o.div_start = 1'b1;
      iac_pkg::ST_DIV:  cmd_o.div_step = 1'b1;
      iac_pkg::ST_MOD:  cmd_o.modify = 1'b1;
      iac_pkg::ST_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != iac_pkg::ST_IDLE) |-> !in_ready_o)
    else $error("input taken while busy");
  a_out_after_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == iac_pkg::ST_MOD)
    else $error("result without modifier step");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped");
`endif
endmodule

[hdl/iac_dp.sv]
// datapath: curve memory, segment scan, serial divider and timing modifiers
module iac_dp #(
  parameter int unsigned CurvePoints = iac_pkg::CurvePointsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  iac_pkg::in_item_t  item_i,
  input  iac_pkg::cfg_t      cfg_i,
  input  iac_pkg::dp_cmd_t   cmd_i,
  output iac_pkg::dp_sts_t   sts_o,
  output iac_pkg::out_item_t res_o
);
  localparam int unsigned AddrW = $clog2(CurvePoints);
  localparam int unsigned CntW = $clog2(CurvePoints + 2);
  localparam logic [CntW-1:0] LastIdx = CntW'(CurvePoints - 1);

  iac_pkg::in_item_t item_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [31:0]       prev_q, rdata;
  logic              found_q, need_div_q, done_q;
  logic signed [15:0] base_q;
  logic [15:0]       dr_q, t1_q;
  logic signed [16:0] dt_q;
  logic [32:0]       rem_q, quo_q;
  logic              neg_q;
  logic [5:0]        dcnt_q;
  logic [15:0]       seg_r1_q;
  iac_pkg::out_item_t res_q;
  logic              pulse_on_q;
  logic [31:0]       pulse_start_q, last_end_q;
  logic [AddrW-1:0]  raddr;
  logic              we;

  assign we = cmd_i.write_pt && (32'(item_q.point_index) < CurvePoints);
  assign raddr = (cmd_i.capture || cmd_i.scan_start) ? '0 : cnt_q[AddrW-1:0];

  iac_ram #(.Width(32), .Depth(CurvePoints)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AddrW'(item_q.point_index)),
    .wdata_i ({item_q.point_timing, item_q.point_rpm}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= item_i;
  end

  // scan: cnt_q is the address being read, rdata holds point cnt_q-1
  logic [15:0] rpm;
  logic [15:0] r_cur, r_prv;
  logic signed [15:0] t_cur, t_prv;
  assign rpm   = item_q.rpm;
  assign r_cur = rdata[15:0];
  assign t_cur = rdata[31:16];
  assign r_prv = prev_q[15:0];
  assign t_prv = prev_q[31:16];

  logic [CntW-1:0] rd_idx;
  assign rd_idx = cnt_q - CntW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      done_q <= 1'b0;
      found_q <= 1'b0;
      need_div_q <= 1'b0;
    end else begin
      if (cmd_i.scan_start) begin
        cnt_q <= CntW'(1);
        done_q <= 1'b0;
        found_q <= 1'b0;
        need_div_q <= 1'b0;
      end else if (cmd_i.scan_step && !done_q) begin
        cnt_q <= cnt_d;
        if (rd_idx == '0) begin
          if (rpm <= r_cur) begin
            found_q <= 1'b1;
            done_q <= 1'b1;
          end
        end else if (!found_q && rpm >= r_prv && rpm <= r_cur) begin
          found_q <= 1'b1;
          need_div_q <= (r_prv != r_cur);
        end
        if (rd_idx == LastIdx) begin
          done_q <= 1'b1;
          if (rpm >= r_cur) need_div_q <= 1'b0;
        end
      end
    end
  end
  assign cnt_d = cnt_q + CntW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && !done_q) begin
      prev_q <= rdata;
      if (rd_idx == '0) begin
        if (rpm <= r_cur) base_q <= t_cur;
      end else if (!found_q && rpm >= r_prv && rpm <= r_cur) begin
        base_q <= t_prv;
        dr_q <= r_cur - r_prv;
        t1_q <= t_prv;
        dt_q <= 17'(t_cur) - 17'(t_prv);
        seg_r1_q <= r_prv;
      end
      if (rd_idx == LastIdx) begin
        if (rpm >= r_cur || (!found_q && !(rpm >= r_prv && rpm <= r_cur)))
          base_q <= t_cur;
      end
    end
  end

  // multiply then restoring divide of magnitude, sign applied after
  logic [32:0] prod_abs;
  logic [33:0] trial;
  logic signed [33:0] prod;
  assign prod = $signed({1'b0, 16'(rpm - seg_r1_q)}) * $signed(dt_q);
  assign prod_abs = prod[33] ? 33'(-prod) : 33'(prod);
  assign trial = {rem_q, quo_q[32]} - {18'd0, dr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= 6'd33;
    end else if (cmd_i.div_step && dcnt_q != '0) begin
      dcnt_q <= dcnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= prod_abs;
      neg_q <= prod[33];
    end else if (cmd_i.div_step && dcnt_q != '0) begin
      if (!trial[33]) begin
        rem_q <= trial[32:0];
        quo_q <= {quo_q[31:0], 1'b1};
      end else begin
        rem_q <= {rem_q[31:0], quo_q[32]};
        quo_q <= {quo_q[31:0], 1'b0};
      end
    end
  end

  logic signed [16:0] q_signed;
  logic signed [15:0] base_fin;
  assign q_signed = neg_q ? -$signed({1'b0, quo_q[15:0]}) : $signed({1'b0, quo_q[15:0]});
  assign base_fin = need_div_q ? 16'($signed(17'($signed(t1_q))) + q_signed) : base_q;

  // modifiers
  logic [15:0] ir, band, lo;
  logic [16:0] hi;
  logic starting, idle, tss, rumble, inwin, bf, pon_d;
  logic [31:0] pstart_d, lend_d;
  logic signed [15:0] t0, t1, t2, t3;
  logic [1:0] mode;

  always_comb begin
    ir = cfg_i.idle_cfg[16:1];
    band = cfg_i.idle_cfg[32:17];
    lo = (ir > band) ? ir - band : 16'd0;
    hi = 17'(ir) + 17'(band);
    starting = (rpm != 16'd0) && (rpm < cfg_i.start_cfg[15:0]);
    idle = cfg_i.idle_cfg[0] && rpm >= lo && 17'(rpm) <= hi;
    t0 = idle ? $signed(cfg_i.idle_cfg[48:33]) : base_fin;
    mode = cfg_i.tss_cfg[1:0];
    tss = (mode == iac_pkg::TSS_AUTO) ? item_q.tss_pin : (mode == iac_pkg::TSS_ON);
    t1 = tss ? iac_pkg::sat16(18'(t0) - 18'(cfg_i.tss_cfg[17:2])) : t0;
    rumble = cfg_i.rumble_cfg[0] && rpm >= cfg_i.rumble_cfg[16:1]
             && rpm <= cfg_i.rumble_cfg[32:17];
    t2 = rumble ? iac_pkg::sat16(18'(t1) - 18'(cfg_i.rumble_cfg[48:33])) : t1;
    inwin = rpm >= cfg_i.backfire_cfg[16:1] && rpm <= cfg_i.backfire_cfg[32:17];
    pon_d = pulse_on_q;
    pstart_d = pulse_start_q;
    lend_d = last_end_q;
    if (!cfg_i.backfire_cfg[0]) begin
      pon_d = 1'b0;
    end else if (pulse_on_q) begin
      if ((item_q.now_ms - pulse_start_q) >= 32'(cfg_i.backfire_times[15:0])) begin
        pon_d = 1'b0;
        lend_d = item_q.now_ms;
      end
    end else if (inwin) begin
      if ((item_q.now_ms - last_end_q) >= 32'(cfg_i.backfire_times[31:16])) begin
        pon_d = 1'b1;
        pstart_d = item_q.now_ms;
      end
    end
    bf = cfg_i.backfire_cfg[0] && pon_d;
    t3 = bf ? iac_pkg::sat16(18'(t2) - 18'(cfg_i.backfire_cfg[48:33])) : t2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_on_q <= 1'b0;
      pulse_start_q <= '0;
      last_end_q <= '0;
    end else if (cmd_i.modify && !starting) begin
      pulse_on_q <= pon_d;
      pulse_start_q <= pstart_d;
      last_end_q <= lend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.modify) begin
      res_q.base_timing <= base_fin;
      res_q.starting <= starting;
      res_q.final_timing <= starting ? $signed(cfg_i.start_cfg[31:16]) : t3;
      res_q.idle_active <= !starting && idle;
      res_q.tss_active <= !starting && tss;
      res_q.rumble_active <= !starting && rumble;
      res_q.backfire_active <= !starting && bf;
      if (rpm >= cfg_i.limit_cfg[31:16]) res_q.limiter_state <= iac_pkg::LIM_HARD;
      else if (rpm >= cfg_i.limit_cfg[15:0]) res_q.limiter_state <= iac_pkg::LIM_SOFT;
      else res_q.limiter_state <= iac_pkg::LIM_NORMAL;
    end
  end

  assign res_o = res_q;
  assign sts_o.is_compute = item_q.opcode == iac_pkg::OP_COMPUTE;
  assign sts_o.scan_done = done_q;
  assign sts_o.need_div = need_div_q;
  assign sts_o.div_done = dcnt_q == '0;

`ifndef ASSERT_OFF
  a_div_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |=> dcnt_q == 6'd33)
    else $error("divider not loaded");
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> dr_q != 16'd0)
    else $error("divide by zero segment");
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan_step && !done_q) |-> cnt_q <= CntW'(CurvePoints))
    else $error("scan past curve");
`endif
endmodule
